@@ src/line_raster_hit_accumulator_defines.svh @@
// Assertion macros used by the line raster hit accumulator top level.
`ifndef LINE_RASTER_HIT_ACCUMULATOR_DEFINES_SVH
`define LINE_RASTER_HIT_ACCUMULATOR_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define LRHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lrha assertion failed");

// Checks that a condition in one cycle leads to another in the next cycle.
`define LRHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrha sequencing assertion failed");

`endif

@@ src/lrha_pkg.sv @@
// Shared types and constants of the line raster hit accumulator.
package lrha_pkg;

  localparam int unsigned COORD_W = 13;
  localparam int unsigned PIX_W   = 14;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned HIT_W   = 16;
  localparam int unsigned PLOT_W  = 14;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PIX_W-1:0]   pix_coord_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic [1:0]                action_t;

  localparam action_t ACT_DRAW  = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       last;
    pix_coord_t px;
    pix_coord_t py;
  } pix_t;

endpackage

@@ src/line_raster_hit_accumulator.sv @@
// Top level of the line raster hit accumulator: sequencer, store and line walker.
// An item is taken at a clock edge with start high and busy low, and its one result
// appears on hit_count_o and pixels_plotted_o for a single cycle with done_o high;
// the receiver cannot hold it off. A draw keeps busy high through three setup steps,
// one step per pixel along the major axis through the walker's error adder and the
// store's read-modify-write port, and one write-back step; its result appears in the
// first cycle with busy low. A read keeps busy high through a request and an output
// state, and a clear sweeps the store one counter per cycle, through all
// 2**($clog2(IMG_W) + $clog2(IMG_H)) counters (65536 at the default size). The same
// sweep runs after reset with busy high and gives no result. Action 3 gives an
// all-zero result in the next cycle and leaves busy low.
`include "line_raster_hit_accumulator_defines.svh"

module line_raster_hit_accumulator #(
  parameter int unsigned IMG_W      = 256,
  parameter int unsigned IMG_H      = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lrha_pkg::action_t             action_i,
  input  lrha_pkg::coord_t              start_x_i,
  input  lrha_pkg::coord_t              start_y_i,
  input  lrha_pkg::coord_t              end_x_i,
  input  lrha_pkg::coord_t              end_y_i,
  input  logic [7:0]                    read_col_i,
  input  logic [7:0]                    read_row_i,
  output logic                          done_o,
  output logic [lrha_pkg::HIT_W-1:0]    hit_count_o,
  output logic [lrha_pkg::PLOT_W-1:0]   pixels_plotted_o
);
  import lrha_pkg::*;

  localparam int unsigned COL_BITS = $clog2(IMG_W);
  localparam int unsigned ROW_BITS = $clog2(IMG_H);
  localparam int unsigned ADDR_W   = COL_BITS + ROW_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;
  localparam logic [2:0] ST_RDREQ = 3'd4;
  localparam logic [2:0] ST_RDOUT = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [ADDR_W-1:0]     clr_addr_q, clr_addr_d;
  logic                  clr_report_q, clr_report_d;
  logic                  wb_valid_q, wb_valid_d;
  logic [ADDR_W-1:0]     wb_addr_q, wb_addr_d;
  logic [PLOT_W-1:0]     plotted_q, plotted_d;
  logic [ADDR_W-1:0]     rd_addr_q, rd_addr_d;
  logic                  rd_in_q, rd_in_d;
  logic                  done_q, done_d;
  logic [HIT_W-1:0]      hit_q, hit_d;
  logic [PLOT_W-1:0]     plot_out_q, plot_out_d;

  logic                  walk_start;
  pix_t                  pix;
  logic                  pix_in;
  logic [ADDR_W-1:0]     pix_addr;
  logic [PIX_W-1:0]      read_col_w, read_row_w;

  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

  lrha_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (walk_start),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .pix_o     (pix)
  );

  lrha_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign pix_in = pix.valid && !pix.px[PIX_W-1] && !pix.py[PIX_W-1]
                  && (pix.px < pix_coord_t'(IMG_W)) && (pix.py < pix_coord_t'(IMG_H));
  assign pix_addr = {pix.py[ROW_BITS-1:0], pix.px[COL_BITS-1:0]};

  assign read_col_w = {6'b0, read_col_i};
  assign read_row_w = {6'b0, read_row_i};

  assign mem_re    = ((state_q == ST_DRAW) && pix_in) || (state_q == ST_RDREQ);
  assign mem_raddr = (state_q == ST_RDREQ) ? rd_addr_q : pix_addr;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = wb_valid_q;
      mem_waddr = wb_addr_q;
      mem_wdata = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    clr_report_d = clr_report_q;
    wb_valid_d   = 1'b0;
    wb_addr_d    = wb_addr_q;
    plotted_d    = plotted_q;
    rd_addr_d    = rd_addr_q;
    rd_in_d      = rd_in_q;
    done_d       = 1'b0;
    hit_d        = '0;
    plot_out_d   = '0;
    walk_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (action_i)
            ACT_DRAW: begin
              walk_start = 1'b1;
              plotted_d  = '0;
              state_d    = ST_DRAW;
            end
            ACT_READ: begin
              rd_addr_d = {read_row_w[ROW_BITS-1:0], read_col_w[COL_BITS-1:0]};
              rd_in_d   = (read_col_w < PIX_W'(IMG_W)) && (read_row_w < PIX_W'(IMG_H));
              state_d   = ST_RDREQ;
            end
            ACT_CLEAR: begin
              clr_addr_d   = '0;
              clr_report_d = 1'b1;
              state_d      = ST_CLEAR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == '1) begin
          done_d       = clr_report_q;
          clr_report_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_DRAW: begin
        if (pix_in) begin
          wb_valid_d = 1'b1;
          wb_addr_d  = pix_addr;
          plotted_d  = plotted_q + PLOT_W'(1);
        end
        if (pix.valid && pix.last) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        done_d     = 1'b1;
        plot_out_d = plotted_q;
        state_d    = ST_IDLE;
      end
      ST_RDREQ: begin
        state_d = ST_RDOUT;
      end
      ST_RDOUT: begin
        done_d  = 1'b1;
        hit_d   = rd_in_q ? HIT_W'(mem_rdata) : '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      clr_report_q <= 1'b0;
      wb_valid_q   <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      clr_report_q <= clr_report_d;
      wb_valid_q   <= wb_valid_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q  <= wb_addr_d;
    plotted_q  <= plotted_d;
    rd_addr_q  <= rd_addr_d;
    rd_in_q    <= rd_in_d;
    hit_q      <= hit_d;
    plot_out_q <= plot_out_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign hit_count_o      = hit_q;
  assign pixels_plotted_o = plot_out_q;

  `LRHA_ASSERT(a_done_when_idle, done_q |-> !busy)
  `LRHA_ASSERT(a_wb_in_draw, wb_valid_q |-> (state_q == ST_DRAW || state_q == ST_WB))
  `LRHA_ASSERT(a_rmw_distinct, (wb_valid_q && mem_re) |-> (mem_raddr != wb_addr_q))
  `LRHA_ASSERT_NEXT(a_clear_holds, (state_q == ST_CLEAR && clr_addr_q != '1), (state_q == ST_CLEAR))

endmodule

@@ src/lrha_store.sv @@
// Counter memory with one write port and one registered read port.
module lrha_store #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lrha_walker.sv @@
// Bresenham line walker that emits one pixel per cycle from a shared error adder.
module lrha_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lrha_pkg::coord_t  start_x_i,
  input  lrha_pkg::coord_t  start_y_i,
  input  lrha_pkg::coord_t  end_x_i,
  input  lrha_pkg::coord_t  end_y_i,
  output lrha_pkg::pix_t    pix_o
);
  import lrha_pkg::*;

  localparam logic [2:0] W_IDLE  = 3'd0;
  localparam logic [2:0] W_NEG   = 3'd1;
  localparam logic [2:0] W_STEEP = 3'd2;
  localparam logic [2:0] W_PREP  = 3'd3;
  localparam logic [2:0] W_RUN   = 3'd4;

  logic [2:0] state_q, state_d;
  pix_coord_t ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  pix_coord_t u_q, u_d, v_q, v_d, end_q, end_d;
  logic       neg_q, neg_d, steep_q, steep_d;
  err_t       d_q, d_d, dy2_q, dy2_d, diff2_q, diff2_d;
  err_t       dx, dy;
  pix_coord_t minor_y;

  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    bx_d    = bx_q;
    by_d    = by_q;
    u_d     = u_q;
    v_d     = v_q;
    end_d   = end_q;
    neg_d   = neg_q;
    steep_d = steep_q;
    d_d     = d_q;
    dy2_d   = dy2_q;
    diff2_d = diff2_q;
    dx      = err_t'(bx_q) - err_t'(ax_q);
    dy      = err_t'(by_q) - err_t'(ay_q);
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          if (start_x_i > end_x_i) begin
            ax_d = pix_coord_t'(end_x_i);
            ay_d = pix_coord_t'(end_y_i);
            bx_d = pix_coord_t'(start_x_i);
            by_d = pix_coord_t'(start_y_i);
          end else begin
            ax_d = pix_coord_t'(start_x_i);
            ay_d = pix_coord_t'(start_y_i);
            bx_d = pix_coord_t'(end_x_i);
            by_d = pix_coord_t'(end_y_i);
          end
          state_d = W_NEG;
        end
      end
      W_NEG: begin
        neg_d = dy[ERR_W-1];
        if (dy[ERR_W-1]) begin
          ay_d = -ay_q;
          by_d = -by_q;
        end
        state_d = W_STEEP;
      end
      W_STEEP: begin
        steep_d = dx < dy;
        if (dx < dy) begin
          ax_d = ay_q;
          ay_d = ax_q;
          bx_d = by_q;
          by_d = bx_q;
        end
        state_d = W_PREP;
      end
      W_PREP: begin
        dy2_d   = dy + dy;
        diff2_d = (dy - dx) + (dy - dx);
        d_d     = (dy + dy) - dx;
        u_d     = ax_q;
        v_d     = ay_q;
        end_d   = bx_q;
        state_d = W_RUN;
      end
      W_RUN: begin
        if (u_q == end_q) begin
          state_d = W_IDLE;
        end else begin
          u_d = u_q + pix_coord_t'(1);
          if (d_q > err_t'(0)) begin
            v_d = v_q + pix_coord_t'(1);
            d_d = d_q + diff2_q;
          end else begin
            d_d = d_q + dy2_q;
          end
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    u_q     <= u_d;
    v_q     <= v_d;
    end_q   <= end_d;
    neg_q   <= neg_d;
    steep_q <= steep_d;
    d_q     <= d_d;
    dy2_q   <= dy2_d;
    diff2_q <= diff2_d;
  end

  assign minor_y     = steep_q ? u_q : v_q;
  assign pix_o.valid = (state_q == W_RUN);
  assign pix_o.last  = (u_q == end_q);
  assign pix_o.px    = steep_q ? v_q : u_q;
  assign pix_o.py    = neg_q ? -minor_y : minor_y;

endmodule

@@ tb/line_raster_hit_accumulator_test.sv @@
// Self-checking testbench for the line raster hit accumulator: draws, reads, clears and unused action codes.
`timescale 1ns / 100ps

module line_raster_hit_accumulator_test;
  import lrha_pkg::*;

  localparam int IMG_W = 256;
  localparam int IMG_H = 256;
  localparam int COUNT_BITS = 16;
  localparam int IMG_PIXELS = IMG_W * IMG_H;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam action_t ACT_NONE = 2'd3;
  localparam int MAX_REPORTS = 25;

  typedef struct packed {
    action_t    act;
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
    logic [7:0] col;
    logic [7:0] row;
    logic [6:0] idle_pct;
  } raster_item_t;

  typedef struct packed {
    logic [HIT_W-1:0]  hit;
    logic [PLOT_W-1:0] plotted;
  } raster_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  action_t           action_i = ACT_DRAW;
  coord_t            start_x_i = '0;
  coord_t            start_y_i = '0;
  coord_t            end_x_i = '0;
  coord_t            end_y_i = '0;
  logic [7:0]        read_col_i = '0;
  logic [7:0]        read_row_i = '0;
  logic              done_o;
  logic [HIT_W-1:0]  hit_count_o;
  logic [PLOT_W-1:0] pixels_plotted_o;

  logic [COUNT_BITS-1:0] hit_mirror [IMG_PIXELS];
  raster_item_t          items_to_send [$];
  raster_result_t        results_due [$];
  raster_item_t          active_item;
  raster_result_t        oldest_due;
  bit                    item_taken = 1'b0;
  int                    cycle_count = 0;
  int                    cycle_limit = 0;
  int                    cycle_budget = 0;
  int                    mismatch_count = 0;
  int                    results_checked = 0;
  int                    draws_taken = 0;
  int                    reads_taken = 0;
  int                    clears_taken = 0;
  int                    unused_taken = 0;

  line_raster_hit_accumulator #(
    .IMG_W(IMG_W),
    .IMG_H(IMG_H),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .action_i(action_i),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i(end_x_i),
    .end_y_i(end_y_i),
    .read_col_i(read_col_i),
    .read_row_i(read_row_i),
    .done_o(done_o),
    .hit_count_o(hit_count_o),
    .pixels_plotted_o(pixels_plotted_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int any_coord();
    return int'($urandom_range(8191)) - 4096;
  endfunction

  function automatic void push_item(action_t act, int sx, int sy, int ex, int ey,
                                    int col, int row, int pct);
    raster_item_t it;
    int span_x;
    int span_y;
    sx = (sx < -4096) ? -4096 : (sx > 4095) ? 4095 : sx;
    sy = (sy < -4096) ? -4096 : (sy > 4095) ? 4095 : sy;
    ex = (ex < -4096) ? -4096 : (ex > 4095) ? 4095 : ex;
    ey = (ey < -4096) ? -4096 : (ey > 4095) ? 4095 : ey;
    it.act = act;
    it.sx = coord_t'(sx);
    it.sy = coord_t'(sy);
    it.ex = coord_t'(ex);
    it.ey = coord_t'(ey);
    it.col = 8'(col);
    it.row = 8'(row);
    it.idle_pct = 7'(pct);
    items_to_send.push_back(it);
    span_x = (ex > sx) ? ex - sx : sx - ex;
    span_y = (ey > sy) ? ey - sy : sy - ey;
    case (act)
      ACT_DRAW: cycle_budget += ((span_x > span_y) ? span_x : span_y) + 8;
      ACT_READ: cycle_budget += 6;
      ACT_CLEAR: cycle_budget += IMG_PIXELS + 8;
      default: cycle_budget += 4;
    endcase
    cycle_budget += (pct != 0) ? 40 : 2;
  endfunction

  function automatic int unsigned mark_pixel(int px, int py);
    int idx;
    if (px < 0 || px >= IMG_W || py < 0 || py >= IMG_H) return 0;
    idx = py * IMG_W + px;
    if (hit_mirror[idx] != COUNT_MAX) hit_mirror[idx] = hit_mirror[idx] + COUNT_BITS'(1);
    return 1;
  endfunction

  function automatic int unsigned trace_line(int ax, int ay, int bx, int by);
    int tmp;
    int dx;
    int dy;
    int err;
    int u;
    int v;
    int px;
    int py;
    bit steep;
    bit flip;
    int unsigned plotted;
    plotted = 0;
    if (ax > bx) begin
      tmp = ax; ax = bx; bx = tmp;
      tmp = ay; ay = by; by = tmp;
    end
    flip = (by < ay);
    if (flip) begin
      ay = -ay;
      by = -by;
    end
    steep = (bx - ax) < (by - ay);
    if (steep) begin
      tmp = ax; ax = ay; ay = tmp;
      tmp = bx; bx = by; by = tmp;
    end
    dx = bx - ax;
    dy = by - ay;
    err = 2 * dy - dx;
    v = ay;
    for (u = ax; u <= bx; u++) begin
      if (steep) begin
        px = v;
        py = flip ? -u : u;
      end else begin
        px = u;
        py = flip ? -v : v;
      end
      plotted += mark_pixel(px, py);
      if (err > 0) begin
        v++;
        err -= 2 * dx;
      end
      err += 2 * dy;
    end
    return plotted;
  endfunction

  function automatic raster_result_t accumulate_item(raster_item_t it);
    raster_result_t res;
    res = '0;
    case (it.act)
      ACT_DRAW: begin
        res.plotted = PLOT_W'(trace_line(int'($signed(it.sx)), int'($signed(it.sy)),
                                         int'($signed(it.ex)), int'($signed(it.ey))));
      end
      ACT_READ: begin
        if (int'(it.col) < IMG_W && int'(it.row) < IMG_H)
          res.hit = hit_mirror[int'(it.row) * IMG_W + int'(it.col)];
      end
      ACT_CLEAR: begin
        for (int i = 0; i < IMG_PIXELS; i++) hit_mirror[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch at cycle %0d, %s: got %0d, expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!start || item_taken)) begin
      item_taken = 1'b0;
      if (items_to_send.size() != 0 && $urandom_range(99) >= items_to_send[0].idle_pct) begin
        active_item = items_to_send.pop_front();
        start <= 1'b1;
        action_i <= active_item.act;
        start_x_i <= active_item.sx;
        start_y_i <= active_item.sy;
        end_x_i <= active_item.ex;
        end_y_i <= active_item.ey;
        read_col_i <= active_item.col;
        read_row_i <= active_item.row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (start && !busy) begin
        results_due.push_back(accumulate_item(active_item));
        item_taken = 1'b1;
        case (active_item.act)
          ACT_DRAW: draws_taken++;
          ACT_READ: reads_taken++;
          ACT_CLEAR: clears_taken++;
          default: unused_taken++;
        endcase
      end
      if (done_o) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due", int'(hit_count_o), 0);
        end else begin
          oldest_due = results_due.pop_front();
          results_checked++;
          if (hit_count_o !== oldest_due.hit)
            report_mismatch("hit_count", int'(hit_count_o), int'(oldest_due.hit));
          if (pixels_plotted_o !== oldest_due.plotted)
            report_mismatch("pixels_plotted", int'(pixels_plotted_o),
                            int'(oldest_due.plotted));
        end
      end
      if (cycle_count > cycle_limit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("line_raster_hit_accumulator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int sx;
    int sy;
    int pick;
    int pct;
    int burst_left;
    int clears_left;
    int last_x;
    int last_y;

    for (int i = 0; i < IMG_PIXELS; i++) hit_mirror[i] = '0;

    push_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    push_item(ACT_DRAW, 10, 20, 10, 20, 0, 0, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 10, 20, 0);
    push_item(ACT_DRAW, 0, 5, 255, 5, 0, 0, 0);
    push_item(ACT_DRAW, 3, -10, 3, 300, 0, 0, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 3, 5, 0);
    push_item(ACT_DRAW, 200, 100, 50, 30, 0, 0, 0);
    for (int o = 0; o < 8; o++) begin
      sx = o[0] ? 15 : 40;
      sy = o[0] ? 40 : 15;
      push_item(ACT_DRAW, 128, 128, 128 + (o[1] ? -sx : sx), 128 + (o[2] ? -sy : sy),
                0, 0, 0);
    end
    push_item(ACT_DRAW, -100, -50, -10, -5, 0, 0, 0);
    push_item(ACT_DRAW, -4096, -4096, 4095, 4095, 255, 255, 0);
    push_item(ACT_DRAW, 4095, -4096, -4096, 4095, 0, 0, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 128, 128, 0);
    push_item(ACT_NONE, any_coord(), any_coord(), any_coord(), any_coord(),
              $urandom_range(255), $urandom_range(255), 0);
    push_item(ACT_READ, 0, 0, 0, 0, 255, 255, 0);
    push_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 128, 128, 0);

    push_item(ACT_DRAW, 77, 33, 77, 33, 0, 0, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 77, 33, 0);
    push_item(ACT_DRAW, 60, 33, 90, 33, 0, 0, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 77, 33, 0);
    push_item(ACT_READ, 0, 0, 0, 0, 78, 33, 0);

    burst_left = 0;
    clears_left = 2;
    last_x = 40;
    last_y = 40;
    for (int ph = 0; ph < 6; ph++) begin
      for (int n = 0; n < 258; n++) begin
        pct = (ph == 1 || ph == 4) ? 73 : (ph == 3 || ph == 5) ? 28 : 0;
        if (pct != 0 && burst_left == 0 && $urandom_range(11) == 0)
          burst_left = $urandom_range(12, 4);
        if (burst_left != 0) begin
          pct = 0;
          burst_left--;
        end
        pick = $urandom_range(999);
        if (pick < 3 && clears_left != 0) begin
          clears_left--;
          push_item(ACT_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                    $urandom_range(255), $urandom_range(255), pct);
        end else if (pick < 30) begin
          push_item(ACT_NONE, any_coord(), any_coord(), any_coord(), any_coord(),
                    $urandom_range(255), $urandom_range(255), pct);
        end else if (pick < 380) begin
          pick = $urandom_range(9);
          if (pick < 4 && last_x >= 0 && last_x < IMG_W && last_y >= 0 && last_y < IMG_H)
            push_item(ACT_READ, any_coord(), any_coord(), any_coord(), any_coord(),
                      last_x, last_y, pct);
          else if (pick < 7)
            push_item(ACT_READ, any_coord(), any_coord(), any_coord(), any_coord(),
                      $urandom_range(100), $urandom_range(100), pct);
          else
            push_item(ACT_READ, any_coord(), any_coord(), any_coord(), any_coord(),
                      $urandom_range(255), $urandom_range(255), pct);
        end else begin
          pick = $urandom_range(99);
          if (pick < 55) begin
            sx = int'($urandom_range(112)) - 16;
            sy = int'($urandom_range(112)) - 16;
            push_item(ACT_DRAW, sx, sy, sx + int'($urandom_range(48)) - 24,
                      sy + int'($urandom_range(48)) - 24,
                      $urandom_range(255), $urandom_range(255), pct);
          end else if (pick < 80) begin
            sx = int'($urandom_range(335)) - 40;
            sy = int'($urandom_range(335)) - 40;
            push_item(ACT_DRAW, sx, sy, sx + int'($urandom_range(120)) - 60,
                      sy + int'($urandom_range(120)) - 60,
                      $urandom_range(255), $urandom_range(255), pct);
          end else if (pick < 97) begin
            sx = any_coord();
            sy = any_coord();
            push_item(ACT_DRAW, sx, sy, sx + int'($urandom_range(80)) - 40,
                      sy + int'($urandom_range(80)) - 40,
                      $urandom_range(255), $urandom_range(255), pct);
          end else begin
            sx = any_coord();
            sy = any_coord();
            push_item(ACT_DRAW, sx, sy, any_coord(), any_coord(),
                      $urandom_range(255), $urandom_range(255), pct);
          end
          last_x = sx;
          last_y = sy;
        end
      end
    end

    cycle_limit = 4 * (cycle_budget + IMG_PIXELS + 64) + 5000;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_to_send.size() != 0 || start) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d draws, %0d reads, %0d clears and %0d unused action codes",
             draws_taken, reads_taken, clears_taken, unused_taken);
    $display("over several idle patterns; %0d results checked in %0d cycles, %0d mismatches.",
             results_checked, cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("line_raster_hit_accumulator regression: pass");
    end else begin
      $display("line_raster_hit_accumulator regression: fail");
    end
    $finish;
  end

endmodule
